/* src/swss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_pkg: sliding window sample statistics constants
// Sizes of the window ring, the running sums and the report accumulator.
// ----------------------------------------------------------------------------
package swss_pkg;

  localparam int WINDOW_DEPTH = 128;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SAMPLE_W     = 24;
  localparam int WSUM_W       = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int WSQ_W        = 2 * SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int RFILL_W      = 16;
  localparam int RSUM_W       = 40;
  localparam int RSQ_W        = 64;
  localparam logic [RFILL_W-1:0] REPORT_LIMIT = 16'hFFFF;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

endpackage

/* src/sliding_window_sample_statistics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sample_statistics: one channel of window and report stats
// Ring of samples with count, mean, stddev, min and max, plus a long-run
// report accumulator, worked out on one shared 128-bit add/subtract unit.
// ----------------------------------------------------------------------------
// One request is taken while the block is idle. To work out its result,
// the steps run in order: a min/max scan reads one ring entry per cycle
// through the memory read port, then for the window and then the report
// the shared adder runs a 64-step restoring division for the mean,
// shift-add products n*Q and S*S (one step per multiplier bit), a 64-step
// division of the variance and a 32-step square root. A clear request
// empties the window and keeps the report. The next request is accepted
// while the previous result still waits in the output register.
module sliding_window_sample_statistics (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        kind,
  input  logic [23:0] sample,
  input  logic        include_in_report,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  window_count,
  output logic [23:0] window_mean,
  output logic [23:0] window_stddev,
  output logic [23:0] window_min,
  output logic [23:0] window_max,
  output logic [15:0] report_count,
  output logic [23:0] report_mean,
  output logic [23:0] report_stddev,
  output logic        report_saturated
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SUB   = 12'b000000000010,
    S_ADD   = 12'b000000000100,
    S_SCAN  = 12'b000000001000,
    S_MEAN  = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_DIFF  = 12'b000001000000,
    S_DCHK  = 12'b000010000000,
    S_DIV   = 12'b000100000000,
    S_DDONE = 12'b001000000000,
    S_SQRT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    P_MEAN = 2'd0,
    P_NQ   = 2'd1,
    P_SS   = 2'd2,
    P_VAR  = 2'd3
  } pur_t;

  state_t state;
  pur_t   pur;

  logic [swss_pkg::SAMPLE_W-1:0] store [swss_pkg::WINDOW_DEPTH];
  logic [swss_pkg::SAMPLE_W-1:0] rd_data;
  logic [swss_pkg::ADDR_W-1:0]   rd_addr;
  logic [swss_pkg::ADDR_W-1:0]   pos;
  logic [swss_pkg::FILL_W-1:0]   fill;
  logic [swss_pkg::WSUM_W-1:0]   wsum;
  logic [swss_pkg::WSQ_W-1:0]    wsq;
  logic [swss_pkg::RFILL_W-1:0]  rfill;
  logic [swss_pkg::RSUM_W-1:0]   rsum;
  logic [swss_pkg::RSQ_W-1:0]    rsq;

  logic [swss_pkg::SAMPLE_W-1:0] sample_r;
  logic                          incl_r;

  logic [swss_pkg::FILL_W-1:0]   si;
  logic                          scan_vld;
  logic                          first;
  logic [23:0]                   mn;
  logic [23:0]                   mx;
  logic                          chan;
  logic [23:0]                   mean_r [2];
  logic [23:0]                   std_r [2];

  logic [127:0] acc;
  logic [127:0] ma;
  logic [63:0]  mb;
  logic [127:0] prod;
  logic [32:0]  rem;
  logic [31:0]  dvs;
  logic [63:0]  num_lo;
  logic [63:0]  sv;
  logic [63:0]  sr;
  logic [63:0]  sbit;
  logic [6:0]   cnt;

  logic [127:0] alu_a;
  logic [127:0] alu_b;
  logic         alu_sub;
  logic [128:0] alu_res;
  logic [23:0]  sq_a;
  logic [23:0]  sq_b;
  logic [47:0]  sq_p;
  logic [15:0]  ch_n;
  logic [39:0]  ch_s;
  logic [63:0]  ch_q;
  logic [32:0]  div_shift;
  logic [127:0] mul_acc;
  logic [63:0]  sr_next;
  logic         full;

  assign full      = (fill == swss_pkg::FILL_W'(swss_pkg::WINDOW_DEPTH));
  assign req_ready = (state == S_IDLE);
  assign rd_addr   = (state == S_SCAN) ? si[swss_pkg::ADDR_W-1:0] : pos;
  assign ch_n      = chan ? rfill : 16'(fill);
  assign ch_s      = chan ? rsum : 40'(wsum);
  assign ch_q      = chan ? rsq : 64'(wsq);
  assign div_shift = {rem[31:0], num_lo[63]};
  assign mul_acc   = mb[0] ? alu_res[127:0] : acc;
  assign sr_next   = alu_res[128] ? ((sr >> 1) | sbit) : (sr >> 1);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    sq_a    = sample_r;
    sq_b    = sample_r;
    unique case (state)
      S_SUB: begin
        sq_a = rd_data;
        sq_b = rd_data;
      end
      S_MUL: begin
        alu_a = acc;
        alu_b = ma;
      end
      S_DIFF: begin
        alu_a   = prod;
        alu_b   = acc;
        alu_sub = 1'b1;
        sq_a    = 24'(ch_n);
        sq_b    = 24'(ch_n - 16'd1);
      end
      S_DCHK: begin
        alu_a   = {64'b0, acc[127:64]};
        alu_b   = {96'b0, dvs};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {95'b0, div_shift};
        alu_b   = {96'b0, dvs};
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = {64'b0, sv};
        alu_b   = {64'b0, sr | sbit};
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + 129'(alu_sub);
    sq_p    = sq_a * sq_b;
  end

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
    if (state == S_ADD) begin
      store[pos] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pur       <= P_MEAN;
      pos       <= '0;
      fill      <= '0;
      wsum      <= '0;
      wsq       <= '0;
      rfill     <= '0;
      rsum      <= '0;
      rsq       <= '0;
      chan      <= 1'b0;
      scan_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            sample_r <= sample;
            incl_r   <= include_in_report;
            if (kind == swss_pkg::KIND_CLEAR) begin
              fill     <= '0;
              pos      <= '0;
              wsum     <= '0;
              wsq      <= '0;
              si       <= '0;
              scan_vld <= 1'b0;
              first    <= 1'b1;
              mn       <= '0;
              mx       <= '0;
              state    <= S_SCAN;
            end else begin
              state <= S_SUB;
            end
          end
        end
        S_SUB: begin
          if (full) begin
            wsum <= wsum - swss_pkg::WSUM_W'(rd_data);
            wsq  <= wsq - swss_pkg::WSQ_W'(sq_p);
          end
          state <= S_ADD;
        end
        S_ADD: begin
          wsum <= wsum + swss_pkg::WSUM_W'(sample_r);
          wsq  <= wsq + swss_pkg::WSQ_W'(sq_p);
          if (!full) begin
            fill <= fill + 1'b1;
          end
          pos <= (pos == swss_pkg::ADDR_W'(swss_pkg::WINDOW_DEPTH - 1)) ? '0 : pos + 1'b1;
          if (incl_r && rfill != swss_pkg::REPORT_LIMIT) begin
            rfill <= rfill + 16'd1;
            rsum  <= rsum + 40'(sample_r);
            rsq   <= rsq + 64'(sq_p);
          end
          si       <= '0;
          scan_vld <= 1'b0;
          first    <= 1'b1;
          mn       <= '0;
          mx       <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (si < fill) begin
            si       <= si + 1'b1;
            scan_vld <= 1'b1;
          end else begin
            scan_vld <= 1'b0;
          end
          if (scan_vld) begin
            first <= 1'b0;
            if (first || rd_data < mn) mn <= rd_data;
            if (first || rd_data > mx) mx <= rd_data;
          end
          if (si == fill && !scan_vld) begin
            chan  <= 1'b0;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (ch_n == 16'd0) begin
            mean_r[chan] <= '0;
            std_r[chan]  <= '0;
            if (!chan) begin
              chan <= 1'b1;
            end else begin
              state <= S_OUT;
            end
          end else begin
            acc   <= {88'b0, ch_s};
            dvs   <= {16'b0, ch_n};
            pur   <= P_MEAN;
            state <= S_DCHK;
          end
        end
        S_DCHK: begin
          if (alu_res[128]) begin
            num_lo <= '1;
            state  <= S_DDONE;
          end else begin
            rem    <= acc[96:64];
            num_lo <= acc[63:0];
            cnt    <= 7'd64;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= alu_res[128] ? alu_res[32:0] : div_shift;
          num_lo <= {num_lo[62:0], alu_res[128]};
          cnt    <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_DDONE;
          end
        end
        S_DDONE: begin
          if (pur == P_MEAN) begin
            mean_r[chan] <= num_lo[23:0];
            if (ch_n < 16'd2) begin
              std_r[chan] <= '0;
              if (!chan) begin
                chan  <= 1'b1;
                state <= S_MEAN;
              end else begin
                state <= S_OUT;
              end
            end else begin
              acc   <= '0;
              ma    <= {64'b0, ch_q};
              mb    <= {48'b0, ch_n};
              pur   <= P_NQ;
              state <= S_MUL;
            end
          end else begin
            sv    <= num_lo;
            sr    <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            cnt   <= 7'd32;
            state <= S_SQRT;
          end
        end
        S_MUL: begin
          if (mb[63:1] == 63'd0 && pur == P_NQ) begin
            prod <= mul_acc;
            acc  <= '0;
            ma   <= {88'b0, ch_s};
            mb   <= {24'b0, ch_s};
            pur  <= P_SS;
          end else begin
            acc <= mul_acc;
            ma  <= {ma[126:0], 1'b0};
            mb  <= mb >> 1;
            if (mb[63:1] == 63'd0) begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          if (alu_res[128]) begin
            acc   <= alu_res[127:0];
            dvs   <= sq_p[31:0];
            pur   <= P_VAR;
            state <= S_DCHK;
          end else begin
            std_r[chan] <= '0;
            if (!chan) begin
              chan  <= 1'b1;
              state <= S_MEAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SQRT: begin
          if (alu_res[128]) begin
            sv <= alu_res[63:0];
          end
          sr   <= sr_next;
          sbit <= sbit >> 2;
          cnt  <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            std_r[chan] <= sr_next[23:0];
            if (!chan) begin
              chan  <= 1'b1;
              state <= S_MEAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            window_count     <= 8'(fill);
            window_mean      <= mean_r[0];
            window_stddev    <= std_r[0];
            window_min       <= mn;
            window_max       <= mx;
            report_count     <= rfill;
            report_mean      <= mean_r[1];
            report_stddev    <= std_r[1];
            report_saturated <= (rfill == swss_pkg::REPORT_LIMIT);
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
